FILE: rtl/dictionary_text_decoder_top_assert.svh
// Assertion macros shared by the dictionary text decoder RTL.
`ifndef DICTIONARY_TEXT_DECODER_TOP_ASSERT_SVH
`define DICTIONARY_TEXT_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold at every rising clock edge out of reset
`define DTD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
// Condition that must never be true out of reset
`define DTD_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define DTD_ASSERT(label, clk, rst_n, prop)
`define DTD_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: rtl/dtd_pkg.sv
// Shared types, constants and helpers for the dictionary text decoder.
package dtd_pkg;

    // Output packing
    localparam int OUT_LANES  = 8;
    localparam int LANE_W     = $clog2(OUT_LANES);
    localparam int TEXT_W     = 8 * OUT_LANES;
    localparam int CNT_W      = 4;

    // Dictionary geometry: one 256-byte slot per entry
    localparam int DICT_ENTRIES = 256;
    localparam int IDX_W        = $clog2(DICT_ENTRIES);
    localparam int POS_W        = 8;
    localparam int WORD_SEL_W   = POS_W - LANE_W;
    localparam int WORD_AW      = IDX_W + WORD_SEL_W;
    localparam int DICT_WORDS   = 2 ** WORD_AW;

    // File signature
    localparam int SIG_LEN   = 9;
    localparam int SIG_POS_W = 4;

    // Command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Front-end parse phase
    typedef enum logic [1:0] {
        PH_SIG,
        PH_LEN,
        PH_BYTES,
        PH_CODES
    } t_phase;

    // Back-end sequencer state
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LEN,
        BK_RUN
    } t_bk_state;

    // Command handed from front to back
    typedef struct packed {
        logic             is_err;
        logic [IDX_W-1:0] code;
    } t_cmd;

    // Dictionary byte write
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
        logic [POS_W-1:0] pos;
        logic [7:0]       data;
    } t_dict_wr;

    // Entry length write
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
        logic [POS_W-1:0] len;
    } t_len_wr;

    // Expected signature byte "!!8-Bit!!" at a given position
    function automatic logic [7:0] sig_byte(input logic [SIG_POS_W-1:0] pos);
        logic [7:0] b;
        unique case (pos)
            4'd0:    b = 8'h21;
            4'd1:    b = 8'h21;
            4'd2:    b = 8'h38;
            4'd3:    b = 8'h2D;
            4'd4:    b = 8'h42;
            4'd5:    b = 8'h69;
            4'd6:    b = 8'h74;
            4'd7:    b = 8'h21;
            4'd8:    b = 8'h21;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/dtd_front.sv
// Front end: accepts file bytes, checks the signature, loads the dictionary, queues codes.
module dtd_front
    import dtd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    output t_dict_wr   o_dict_wr,
    output t_len_wr    o_len_wr,
    output logic       o_push,
    output t_cmd       o_cmd,
    input  logic       i_q_full
);

    t_phase               r_phase, n_phase;
    logic [SIG_POS_W-1:0] r_sig_pos, n_sig_pos;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [POS_W-1:0]     r_left, n_left;
    logic [POS_W-1:0]     r_wpos, n_wpos;
    logic                 r_zero, n_zero;
    logic                 r_failed, n_failed;

    logic                 take;
    logic                 sig_bad;
    logic                 byte_zero;
    logic                 store_byte;
    t_phase               ne_phase;
    logic [IDX_W-1:0]     ne_idx;

    // Any transaction is taken while the queue has room
    assign o_ready    = !i_q_full;
    assign take       = i_valid && o_ready && !r_failed;
    assign sig_bad    = (i_in_byte != sig_byte(r_sig_pos));
    assign byte_zero  = (i_in_byte == 8'h00);
    assign store_byte = (r_phase == PH_BYTES) && !r_zero && !byte_zero;

    // Step to the next entry, or into code mode after the last one
    always_comb begin
        if (r_idx == '1) begin
            ne_idx   = '0;
            ne_phase = PH_CODES;
        end else begin
            ne_idx   = r_idx + 1'b1;
            ne_phase = PH_LEN;
        end
    end

    // Next state
    always_comb begin
        n_phase   = r_phase;
        n_sig_pos = r_sig_pos;
        n_idx     = r_idx;
        n_left    = r_left;
        n_wpos    = r_wpos;
        n_zero    = r_zero;
        n_failed  = r_failed;
        if (take) begin
            unique case (r_phase)
                PH_SIG: begin
                    if (sig_bad) begin
                        n_failed = 1'b1;
                    end else begin
                        n_sig_pos = r_sig_pos + 1'b1;
                        if (r_sig_pos == SIG_POS_W'(SIG_LEN - 1)) begin
                            n_phase = PH_LEN;
                            n_idx   = '0;
                        end
                    end
                end
                PH_LEN: begin
                    n_wpos = '0;
                    n_zero = 1'b0;
                    n_left = i_in_byte;
                    if (byte_zero) begin
                        n_idx   = ne_idx;
                        n_phase = ne_phase;
                    end else begin
                        n_phase = PH_BYTES;
                    end
                end
                PH_BYTES: begin
                    if (byte_zero) begin
                        n_zero = 1'b1;
                    end
                    if (store_byte) begin
                        n_wpos = r_wpos + 1'b1;
                    end
                    n_left = r_left - 1'b1;
                    if (r_left == POS_W'(1)) begin
                        n_idx   = ne_idx;
                        n_phase = ne_phase;
                    end
                end
                PH_CODES: begin
                    n_phase = PH_CODES;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Outputs: memory writes and queued commands
    always_comb begin
        o_dict_wr.we   = take && store_byte;
        o_dict_wr.idx  = r_idx;
        o_dict_wr.pos  = r_wpos;
        o_dict_wr.data = i_in_byte;

        o_len_wr.we    = take && ((r_phase == PH_LEN) || store_byte);
        o_len_wr.idx   = r_idx;
        o_len_wr.len   = (r_phase == PH_LEN) ? '0 : r_wpos + 1'b1;

        o_push         = take && (((r_phase == PH_SIG) && sig_bad) || (r_phase == PH_CODES));
        o_cmd.is_err   = (r_phase == PH_SIG);
        o_cmd.code     = i_in_byte;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SIG;
            r_sig_pos <= '0;
            r_idx     <= '0;
            r_left    <= '0;
            r_wpos    <= '0;
            r_zero    <= 1'b0;
            r_failed  <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_sig_pos <= n_sig_pos;
            r_idx     <= n_idx;
            r_left    <= n_left;
            r_wpos    <= n_wpos;
            r_zero    <= n_zero;
            r_failed  <= n_failed;
        end
    end

endmodule

FILE: rtl/dtd_queue.sv
// Small command FIFO between the front end and the back end.
`include "dictionary_text_decoder_top_assert.svh"
module dtd_queue
    import dtd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_nempty,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full   = (r_cnt == (Q_AW + 1)'(Q_DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_cmd    = r_mem[r_rd];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_nempty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `DTD_ASSERT_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full)
    `DTD_ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && !o_nempty)
    `DTD_ASSERT(a_cnt_range, i_clk, i_rst_n, r_cnt <= (Q_AW + 1)'(Q_DEPTH))

endmodule

FILE: rtl/dtd_back.sv
// Back end: holds the dictionary memories and emits packed text for each code, or an error transaction.
`include "dictionary_text_decoder_top_assert.svh"
module dtd_back
    import dtd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dict_wr          i_dict_wr,
    input  t_len_wr           i_len_wr,
    input  logic              i_q_valid,
    input  t_cmd              i_q_cmd,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [TEXT_W-1:0] o_text_bytes,
    output logic [CNT_W-1:0]  o_byte_count,
    output logic              o_run_last,
    output logic              o_status
);

    // Dictionary as words of OUT_LANES bytes, written one byte lane at a time
    logic [TEXT_W-1:0] r_dict [DICT_WORDS];
    logic [POS_W-1:0]  r_lens [DICT_ENTRIES];

    t_bk_state         r_state, n_state;
    logic [IDX_W-1:0]  r_code, n_code;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_len;
    logic [POS_W-1:0]  r_len_rd;
    logic [TEXT_W-1:0] r_rd_word;

    logic              r_ovalid;
    logic [TEXT_W-1:0] r_text;
    logic [CNT_W-1:0]  r_count;
    logic              r_last;
    logic              r_status;

    logic               out_free;
    logic               load_err;
    logic               load_word;
    logic [POS_W-1:0]   rem;
    logic [CNT_W-1:0]   word_cnt;
    logic               word_last;
    logic [TEXT_W-1:0]  word_masked;
    logic [WORD_AW-1:0] rd_addr;

    assign out_free  = !r_ovalid || i_ready;
    assign rem       = r_len - r_pos;
    assign word_last = (rem <= POS_W'(OUT_LANES));
    assign word_cnt  = word_last ? rem[CNT_W-1:0] : CNT_W'(OUT_LANES);

    // Zero the lanes past the valid count
    always_comb begin
        for (int k = 0; k < OUT_LANES; k++) begin
            word_masked[8*k +: 8] = (CNT_W'(k) < word_cnt) ? r_rd_word[8*k +: 8] : 8'h00;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid && out_free && !i_q_cmd.is_err) begin
                    n_state = BK_LEN;
                end
            end
            BK_LEN: begin
                n_state = (r_len_rd == '0) ? BK_IDLE : BK_RUN;
            end
            BK_RUN: begin
                if (out_free && word_last) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Sequencer outputs: queue pop, result loads, read address
    always_comb begin
        o_pop     = (r_state == BK_IDLE) && i_q_valid && out_free;
        load_err  = o_pop && i_q_cmd.is_err;
        load_word = (r_state == BK_RUN) && out_free;
        n_code    = o_pop ? i_q_cmd.code : r_code;
        if (r_state == BK_LEN) begin
            n_pos = '0;
        end else if (load_word) begin
            n_pos = r_pos + POS_W'(OUT_LANES);
        end else begin
            n_pos = r_pos;
        end
        // Address the word that will be needed next cycle
        rd_addr = {n_code, n_pos[POS_W-1:LANE_W]};
    end

    // Dictionary memory
    always_ff @(posedge i_clk) begin
        if (i_dict_wr.we) begin
            r_dict[{i_dict_wr.idx, i_dict_wr.pos[POS_W-1:LANE_W]}]
                [8*i_dict_wr.pos[LANE_W-1:0] +: 8] <= i_dict_wr.data;
        end
        r_rd_word <= r_dict[rd_addr];
    end

    // Entry length memory
    always_ff @(posedge i_clk) begin
        if (i_len_wr.we) begin
            r_lens[i_len_wr.idx] <= i_len_wr.len;
        end
        r_len_rd <= r_lens[i_q_cmd.code];
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_code <= n_code;
        r_pos  <= n_pos;
        if (r_state == BK_LEN) begin
            r_len <= r_len_rd;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_err || load_word) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
        if (load_err) begin
            r_text   <= '0;
            r_count  <= '0;
            r_last   <= 1'b1;
            r_status <= 1'b1;
        end else if (load_word) begin
            r_text   <= word_masked;
            r_count  <= word_cnt;
            r_last   <= word_last;
            r_status <= 1'b0;
        end
    end

    assign o_valid      = r_ovalid;
    assign o_text_bytes = r_text;
    assign o_byte_count = r_count;
    assign o_run_last   = r_last;
    assign o_status     = r_status;

    `DTD_ASSERT(a_err_shape, i_clk, i_rst_n, o_valid && o_status |-> o_byte_count == '0 && o_run_last)
    `DTD_ASSERT(a_data_cnt, i_clk, i_rst_n, o_valid && !o_status |-> o_byte_count != '0 && o_byte_count <= CNT_W'(OUT_LANES))
    `DTD_ASSERT(a_run_pos, i_clk, i_rst_n, r_state == BK_RUN |-> r_pos < r_len)

endmodule

FILE: rtl/dictionary_text_decoder_top.sv
// Dictionary text decoder, top level.
// Input channel (i_valid/o_ready/i_in_byte) takes the compressed file one byte per
// transaction: a nine-byte signature, then 256 dictionary entries (a length byte and
// that many bytes, usable text ending at the first zero byte), then code bytes.
// Output channel (o_valid/i_ready) carries packed text, up to 8 bytes per transaction,
// first byte in the low lane; o_run_last marks the final transaction of a code.
// A signature mismatch gives one transaction with o_status set; all later input is
// taken and ignored until reset.
// Signature and dictionary bytes are taken one per cycle. A code goes through a
// 4-deep command queue to the back end, which pops it, reads the entry length, then
// gives one result per cycle while i_ready is high; the next code is popped only
// after the last result. Rate is set by the dictionary memory, which delivers one
// 8-byte word per cycle.
// An empty entry gives no output transaction.
// Reset (synchronous, i_rst_n low) returns to signature checking and empties the queue.
// When the receiver stalls the result holds; codes keep being taken until the queue
// is full, then o_ready drops.
module dictionary_text_decoder_top
    import dtd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_in_byte,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [TEXT_W-1:0] o_text_bytes,
    output logic [CNT_W-1:0]  o_byte_count,
    output logic              o_run_last,
    output logic              o_status
);

    t_dict_wr dict_wr;
    t_len_wr  len_wr;
    logic     q_push;
    t_cmd     q_in;
    logic     q_full;
    logic     q_nempty;
    t_cmd     q_out;
    logic     q_pop;

    // Parse and classify
    dtd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_in_byte (i_in_byte),
        .o_dict_wr (dict_wr),
        .o_len_wr  (len_wr),
        .o_push    (q_push),
        .o_cmd     (q_in),
        .i_q_full  (q_full)
    );

    // Decouple front and back
    dtd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_cmd    (q_in),
        .o_full   (q_full),
        .o_nempty (q_nempty),
        .o_cmd    (q_out),
        .i_pop    (q_pop)
    );

    // Expand codes
    dtd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dict_wr    (dict_wr),
        .i_len_wr     (len_wr),
        .i_q_valid    (q_nempty),
        .i_q_cmd      (q_out),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_text_bytes (o_text_bytes),
        .o_byte_count (o_byte_count),
        .o_run_last   (o_run_last),
        .o_status     (o_status)
    );

endmodule

FILE: dv/dictionary_text_decoder_top_tb.sv
// Self-checking testbench for the dictionary text decoder top level.
`timescale 1ns / 1ps

module dictionary_text_decoder_top_tb;
    import dtd_pkg::*;

    localparam int CYCLE_LIMIT  = 500_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_PCT     = 29;
    localparam int RANDOM_CODES = 300;
    localparam logic [8*SIG_LEN-1:0] FILE_SIG = "!!8-Bit!!";

    // One packed text transaction as the output channel carries it
    typedef struct packed {
        logic [TEXT_W-1:0] text;
        logic [CNT_W-1:0]  lanes;
        logic              last;
        logic              bad_sig;
    } t_text_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [7:0]        i_in_byte;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [TEXT_W-1:0] o_text_bytes;
    logic [CNT_W-1:0]  o_byte_count;
    logic              o_run_last;
    logic              o_status;

    // Decoder state mirrored in the testbench
    t_phase          file_phase;
    logic [3:0]      sig_pos;
    logic [7:0]      entry_idx;
    logic [7:0]      entry_left;
    logic            zero_hit;
    logic            sig_failed;
    logic [7:0]      dict_mem [0:65535];
    logic [7:0]      entry_len [0:255];

    t_text_word      text_words_due [$];
    int unsigned     mismatch_count = 0;
    int unsigned     cycle_count = 0;
    bit              calm_mode = 1'b0;

    dictionary_text_decoder_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_byte    (i_in_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_text_bytes (o_text_bytes),
        .o_byte_count (o_byte_count),
        .o_run_last   (o_run_last),
        .o_status     (o_status)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Run-away guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("dictionary_text_decoder_top_tb failed");
            $finish;
        end
    end

    // Receiver: random stalls unless in a calm stretch
    always @(negedge i_clk) begin
        i_ready <= calm_mode || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Step past one dictionary entry, into code phase after the last one
    function automatic void close_entry();
        if (entry_idx == 8'(DICT_ENTRIES - 1)) begin
            entry_idx  = '0;
            file_phase = PH_CODES;
        end else begin
            entry_idx  = entry_idx + 8'd1;
            file_phase = PH_LEN;
        end
    endfunction

    // Advance the mirrored state by one file byte and queue the text it yields
    function automatic void decode_file_byte(input logic [7:0] b);
        int unsigned len;
        int unsigned pos;
        int unsigned cnt;
        logic [TEXT_W-1:0] word;
        if (sig_failed)
            return;
        unique case (file_phase)
            PH_SIG: begin
                if (sig_pos >= SIG_LEN || b != FILE_SIG[8*(SIG_LEN-1-sig_pos) +: 8]) begin
                    sig_failed = 1'b1;
                    text_words_due.push_back('{text: '0, lanes: '0, last: 1'b1,
                                               bad_sig: 1'b1});
                end else begin
                    sig_pos = sig_pos + 4'd1;
                    if (sig_pos == SIG_LEN) begin
                        file_phase = PH_LEN;
                        entry_idx  = '0;
                    end
                end
            end
            PH_LEN: begin
                entry_len[entry_idx] = '0;
                zero_hit   = 1'b0;
                entry_left = b;
                if (b == 8'd0)
                    close_entry();
                else
                    file_phase = PH_BYTES;
            end
            PH_BYTES: begin
                // text stops at the first zero byte; the rest is consumed only
                if (b == 8'd0)
                    zero_hit = 1'b1;
                if (!zero_hit) begin
                    dict_mem[{entry_idx, entry_len[entry_idx]}] = b;
                    entry_len[entry_idx] = entry_len[entry_idx] + 8'd1;
                end
                entry_left = entry_left - 8'd1;
                if (entry_left == 8'd0)
                    close_entry();
            end
            default: begin
                len = entry_len[b];
                pos = 0;
                while (pos < len) begin
                    cnt  = (len - pos > OUT_LANES) ? OUT_LANES : len - pos;
                    word = '0;
                    for (int k = 0; k < cnt; k++)
                        word[8*k +: 8] = dict_mem[{b, 8'(pos + k)}];
                    pos += cnt;
                    text_words_due.push_back('{text: word, lanes: CNT_W'(cnt),
                                               last: (pos >= len), bad_sig: 1'b0});
                end
            end
        endcase
    endfunction

    // Send one file byte; entered and left just after a falling edge
    task automatic send_file_byte(input logic [7:0] b);
        while (!calm_mode && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        decode_file_byte(b);
        @(negedge i_clk);
    endtask

    // Check each output transaction against the oldest pending text word
    always @(posedge i_clk) begin
        t_text_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (text_words_due.size() == 0) begin
                $error("unexpected transaction: text_bytes %h byte_count %0d",
                       o_text_bytes, o_byte_count);
                mismatch_count++;
            end else begin
                want = text_words_due.pop_front();
                if (o_text_bytes !== want.text) begin
                    $error("text_bytes expected %h got %h", want.text, o_text_bytes);
                    mismatch_count++;
                end
                if (o_byte_count !== want.lanes) begin
                    $error("byte_count expected %0d got %0d", want.lanes, o_byte_count);
                    mismatch_count++;
                end
                if (o_run_last !== want.last) begin
                    $error("run_last expected %0b got %0b", want.last, o_run_last);
                    mismatch_count++;
                end
                if (o_status !== want.bad_sig) begin
                    $error("status expected %0b got %0b", want.bad_sig, o_status);
                    mismatch_count++;
                end
            end
        end
    end

    // Correct signature; a bad one locks the block until reset, so it is not sent here
    task automatic test_signature();
        for (int i = 0; i < SIG_LEN; i++)
            send_file_byte(FILE_SIG[8*(SIG_LEN-1-i) +: 8]);
    endtask

    // Full dictionary: fixed corner entries at low indexes and 255, random elsewhere
    task automatic test_dictionary_load();
        int unsigned decl_len;
        int          zero_at;
        logic [7:0]  b;
        for (int idx = 0; idx < DICT_ENTRIES; idx++) begin
            zero_at = -1;
            unique case (idx)
                0:   decl_len = 0;                              // empty by length
                1:   decl_len = 255;                            // longest run
                2:   begin decl_len = 20; zero_at = 5; end      // cut short by zero
                3:   begin decl_len = 4; zero_at = 0; end       // zero first, empty text
                4:   decl_len = 8;
                5:   decl_len = 9;
                6:   decl_len = 1;
                7:   decl_len = 16;
                255: begin decl_len = 255; zero_at = 254; end
                default: begin
                    decl_len = ($urandom_range(0, 31) == 0) ? $urandom_range(25, 255)
                                                            : $urandom_range(0, 24);
                    if (decl_len > 0 && $urandom_range(0, 5) == 0)
                        zero_at = $urandom_range(0, decl_len - 1);
                end
            endcase
            send_file_byte(8'(decl_len));
            for (int p = 0; p < decl_len; p++) begin
                if (p == zero_at)
                    b = 8'h00;
                else if (idx == 6)
                    b = 8'hFF;
                else if (zero_at >= 0 && p > zero_at && $urandom_range(0, 3) == 0)
                    b = 8'h00;
                else
                    b = 8'($urandom_range(1, 255));
                send_file_byte(b);
            end
        end
    endtask

    // Codes that hit each corner entry, extremes of the code byte, repeats
    task automatic test_directed_codes();
        logic [7:0] picks [12] = '{8'd1, 8'd0, 8'd2, 8'd3, 8'd4, 8'd5,
                                   8'd6, 8'd7, 8'd255, 8'd1, 8'd1, 8'd0};
        foreach (picks[i])
            send_file_byte(picks[i]);
    endtask

    // Random codes: gaps and stalls first, then a stretch with neither
    task automatic test_random_codes();
        logic [7:0] code;
        for (int n = 0; n < RANDOM_CODES; n++) begin
            if (n == (2 * RANDOM_CODES) / 3)
                calm_mode = 1'b1;
            if ($urandom_range(0, 7) == 0)
                code = ($urandom_range(0, 1) != 0) ? 8'(
                       $urandom_range(0, 7)) : 8'd255;
            else
                code = 8'($urandom_range(0, 255));
            send_file_byte(code);
        end
        calm_mode = 1'b0;
    endtask

    initial begin
        file_phase = PH_SIG;
        sig_pos    = '0;
        entry_idx  = '0;
        entry_left = '0;
        zero_hit   = 1'b0;
        sig_failed = 1'b0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_in_byte  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_signature();
        test_dictionary_load();
        test_directed_codes();
        test_random_codes();
        i_valid <= 1'b0;

        // let the last results drain, then watch for strays
        while (text_words_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && text_words_due.size() == 0) begin
            $display("dictionary_text_decoder_top_tb passed");
        end else begin
            $display("dictionary_text_decoder_top_tb failed");
        end
        $finish;
    end

endmodule
